[rtl/core/chm_pkg.sv]
// ----------------------------------------------------------------------------
// chm_pkg
// Shared codes, field widths and the memory control bundle of the chained
// hash map engine.
// ----------------------------------------------------------------------------
package chm_pkg;

    // field widths fixed by the item format
    localparam int KEY_W   = 64;
    localparam int VAL_W   = 16;
    localparam int CNT_W   = 11;
    localparam int CFG_W   = 11;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 3;
    localparam int HASH_W  = 64;

    // h * 31 is formed as (h << 5) - h
    localparam int HASH_SHIFT = 5;

    // reset value of the bucket count register
    localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = 11'd1024;

    // commands, code three acts as a lookup
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SPARE  = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STAT_W-1:0] ST_PRESENT  = 3'd1;
    localparam logic [STAT_W-1:0] ST_REMOVED  = 3'd2;
    localparam logic [STAT_W-1:0] ST_FOUND    = 3'd3;
    localparam logic [STAT_W-1:0] ST_ABSENT   = 3'd4;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd5;

    // strobes from the sequencer to the table memories
    typedef struct packed {
        logic head_re;
        logic head_we;
        logic node_re;
        logic link_re;
        logic data_we;
        logic link_we;
    } t_mem_ctl;

endpackage

[rtl/core/chm_hash.sv]
// ----------------------------------------------------------------------------
// chm_hash
// Serial bucket index unit: folds one key byte per cycle as h = h*31 + byte,
// then reduces h modulo the bucket count one bit per cycle.
// ----------------------------------------------------------------------------
module chm_hash #(
    parameter int KEY_BYTES = 16,
    parameter int MW        = 11,
    parameter int BW        = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [2*chm_pkg::KEY_W-1:0]   i_key,      // key bytes, byte 0 lowest
    input  logic [MW-1:0]                 i_modulus,
    output logic                          o_done,
    output logic [BW-1:0]                 o_bucket
);
    import chm_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_FOLD = 2'd1;
    localparam logic [1:0] PH_MOD  = 2'd2;
    localparam logic [3:0] KB_LAST = 4'(KEY_BYTES - 1);

    logic [1:0]        r_phase, n_phase;
    logic [3:0]        r_cnt;
    logic [5:0]        r_bit;
    logic [HASH_W-1:0] r_h;
    logic [MW-1:0]     r_rem;
    logic              r_done;

    logic [7:0]        s_byte;
    logic [HASH_W-1:0] s_h_next;
    logic [MW:0]       s_rem2;
    logic [MW:0]       s_rem_sub;
    logic [MW-1:0]     s_rem_next;

    // one fold step and one restoring remainder step
    always_comb begin
        s_byte     = i_key[{r_cnt, 3'b000} +: 8];
        s_h_next   = (r_h << HASH_SHIFT) - r_h + HASH_W'(s_byte);
        s_rem2     = {r_rem, r_h[r_bit]};
        s_rem_sub  = s_rem2 - {1'b0, i_modulus};
        s_rem_next = (s_rem2 >= {1'b0, i_modulus}) ? s_rem_sub[MW-1:0] : s_rem2[MW-1:0];
    end

    // phase sequencing
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_IDLE: if (i_start) n_phase = PH_FOLD;
            PH_FOLD: if (r_cnt == KB_LAST) n_phase = PH_MOD;
            PH_MOD:  if (r_bit == 6'd0) n_phase = PH_IDLE;
            default: n_phase = PH_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= (r_phase == PH_MOD) && (r_bit == 6'd0);
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_phase)
            PH_IDLE: begin
                r_h   <= '0;
                r_cnt <= '0;
                r_bit <= 6'd63;
                r_rem <= '0;
            end
            PH_FOLD: begin
                r_h   <= s_h_next;
                r_cnt <= r_cnt + 4'd1;
            end
            PH_MOD: begin
                r_rem <= s_rem_next;
                r_bit <= r_bit - 6'd1;
            end
            default: r_h <= r_h;
        endcase
    end

    assign o_done   = r_done;
    assign o_bucket = r_rem[BW-1:0];

endmodule

[rtl/core/chm_tables.sv]
// ----------------------------------------------------------------------------
// chm_tables
// Bucket head, node data and node link memories, one port each, read data
// registered, valid in the cycle after the read strobe.
// ----------------------------------------------------------------------------
module chm_tables #(
    parameter int BUCKETS_MAX = 1024,
    parameter int NODES_MAX   = 1024,
    parameter int BW          = 10,
    parameter int NA          = 10,
    parameter int PW          = 11
) (
    input  logic                          i_clk,
    input  chm_pkg::t_mem_ctl             i_ctl,
    input  logic [BW-1:0]                 i_head_addr,
    input  logic [PW-1:0]                 i_head_wdata,
    output logic [PW-1:0]                 o_head_q,
    input  logic [NA-1:0]                 i_node_addr,
    input  logic [2*chm_pkg::KEY_W+chm_pkg::VAL_W-1:0] i_data_wdata,
    input  logic [PW-1:0]                 i_link_wdata,
    output logic [2*chm_pkg::KEY_W+chm_pkg::VAL_W-1:0] o_data_q,
    output logic [PW-1:0]                 o_link_q
);
    import chm_pkg::*;

    localparam int DW = 2 * KEY_W + VAL_W;

    logic [PW-1:0] head_mem [BUCKETS_MAX];
    logic [DW-1:0] data_mem [NODES_MAX];
    logic [PW-1:0] link_mem [NODES_MAX];

    logic [PW-1:0] r_head_q;
    logic [DW-1:0] r_data_q;
    logic [PW-1:0] r_link_q;

    // bucket heads
    always_ff @(posedge i_clk) begin
        if (i_ctl.head_we) head_mem[i_head_addr] <= i_head_wdata;
        if (i_ctl.head_re) r_head_q <= head_mem[i_head_addr];
    end

    // node keys and handles
    always_ff @(posedge i_clk) begin
        if (i_ctl.data_we) data_mem[i_node_addr] <= i_data_wdata;
        if (i_ctl.node_re) r_data_q <= data_mem[i_node_addr];
    end

    // node links, shared by chains and the free list
    always_ff @(posedge i_clk) begin
        if (i_ctl.link_we) link_mem[i_node_addr] <= i_link_wdata;
        if (i_ctl.node_re || i_ctl.link_re) r_link_q <= link_mem[i_node_addr];
    end

    assign o_head_q = r_head_q;
    assign o_data_q = r_data_q;
    assign o_link_q = r_link_q;

endmodule

[rtl/core/chained_hash_map_engine.sv]
// ----------------------------------------------------------------------------
// chained_hash_map_engine
// Hash map of fixed-length keys to value handles with separate chaining:
// insert, remove and lookup, one transaction at a time.
// ----------------------------------------------------------------------------
//  channel   direction  content
//  s_axis    in         tuser: command; tdata: key_low, key_high, value_handle
//  m_axis    out        tuser: status; tdata: stored_value, entry_count
//  cfg       in         write of bucket_count
//
//  An item passes from one accept to the next through the key fold, the serial
//  modulo (one bit per cycle) and the one-node-per-cycle chain walk over the
//  memory, then S_INS for an insert or S_REM1 and S_REM2 for a remove, and
//  S_OUT, which holds while the output register is still full and stalled.
//  After reset a clearing pass sets every bucket head to NIL and links the
//  free list; no transaction is taken meanwhile.
//  A result waits in the output register; the next item is taken meanwhile.
// ----------------------------------------------------------------------------
module chained_hash_map_engine #(
    parameter int BUCKETS_MAX = 1024,
    parameter int NODES_MAX   = 1024,
    parameter int KEY_BYTES   = 16,
    parameter int VALUE_BITS  = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // [63:0] key_low, [127:64] key_high, [143:128] value_handle
    input  logic [143:0]                i_s_axis_tdata,
    // [1:0] command
    input  logic [chm_pkg::CMD_W-1:0]   i_s_axis_tuser,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // [15:0] stored_value, [26:16] entry_count, [31:27] zero
    output logic [31:0]                 o_m_axis_tdata,
    // [2:0] status
    output logic [chm_pkg::STAT_W-1:0]  o_m_axis_tuser,
    input  logic                        i_cfg_we,
    input  logic [chm_pkg::CFG_W-1:0]   i_cfg_wdata
);
    import chm_pkg::*;

    localparam int BW    = (BUCKETS_MAX > 1) ? $clog2(BUCKETS_MAX) : 1;
    localparam int MW    = $clog2(BUCKETS_MAX + 1);
    localparam int NA    = (NODES_MAX > 1) ? $clog2(NODES_MAX) : 1;
    localparam int PW    = $clog2(NODES_MAX + 1);
    localparam int CLR_N = (BUCKETS_MAX > NODES_MAX) ? BUCKETS_MAX : NODES_MAX;
    localparam int XW    = $clog2(CLR_N + 1);
    localparam int DW    = 2 * KEY_W + VAL_W;

    localparam logic [PW-1:0]      NIL      = PW'(NODES_MAX);
    localparam logic [2*KEY_W-1:0] KEY_MASK = (KEY_BYTES >= 16) ? '1 :
        ((128'd1 << (8 * KEY_BYTES)) - 128'd1);
    localparam logic [VAL_W-1:0]   VAL_MASK = (VALUE_BITS >= VAL_W) ? '1 :
        VAL_W'((32'd1 << VALUE_BITS) - 32'd1);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_HASH = 4'd2;
    localparam logic [3:0] S_HGET = 4'd3;
    localparam logic [3:0] S_NCMP = 4'd4;
    localparam logic [3:0] S_INS  = 4'd5;
    localparam logic [3:0] S_REM1 = 4'd6;
    localparam logic [3:0] S_REM2 = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0]         r_state, n_state;
    logic [XW-1:0]      r_clr, n_clr;
    logic [PW-1:0]      r_free, n_free;
    logic [PW-1:0]      r_count, n_count;
    logic [PW-1:0]      r_p, n_p;
    logic [PW-1:0]      r_prev, n_prev;
    logic [PW-1:0]      r_steps, n_steps;
    logic [PW-1:0]      r_head, n_head;
    logic [BW-1:0]      r_bucket, n_bucket;
    logic [STAT_W-1:0]  r_status, n_status;
    logic [VAL_W-1:0]   r_sv, n_sv;
    logic [CFG_W-1:0]   r_bc;
    logic [CMD_W-1:0]   r_cmd;
    logic [2*KEY_W-1:0] r_key;
    logic [VAL_W-1:0]   r_val;
    logic               r_start;
    logic               r_ovalid;
    logic [31:0]        r_odata;
    logic [STAT_W-1:0]  r_ouser;

    logic               s_accept;
    logic               s_oload;
    logic [MW-1:0]      s_modulus;
    logic               hs_done;
    logic [BW-1:0]      hs_bucket;
    t_mem_ctl           s_ctl;
    logic [BW-1:0]      s_head_addr;
    logic [PW-1:0]      s_head_wdata;
    logic [PW-1:0]      head_q;
    logic [NA-1:0]      s_node_addr;
    logic [PW-1:0]      s_link_wdata;
    logic [DW-1:0]      data_q;
    logic [PW-1:0]      link_q;
    logic               s_end;
    logic               s_hit;

    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_oload         = (r_state == S_OUT) && (!r_ovalid || i_m_axis_tready);

    // effective modulus: zero reads as one, clipped at the table size
    always_comb begin
        if (r_bc == '0)
            s_modulus = MW'(1);
        else if (32'(r_bc) > 32'(BUCKETS_MAX))
            s_modulus = MW'(BUCKETS_MAX);
        else
            s_modulus = MW'(r_bc);
    end

    chm_hash #(
        .KEY_BYTES (KEY_BYTES),
        .MW        (MW),
        .BW        (BW)
    ) u_hash (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_start),
        .i_key     (r_key),
        .i_modulus (s_modulus),
        .o_done    (hs_done),
        .o_bucket  (hs_bucket)
    );

    chm_tables #(
        .BUCKETS_MAX (BUCKETS_MAX),
        .NODES_MAX   (NODES_MAX),
        .BW          (BW),
        .NA          (NA),
        .PW          (PW)
    ) u_tables (
        .i_clk        (i_clk),
        .i_ctl        (s_ctl),
        .i_head_addr  (s_head_addr),
        .i_head_wdata (s_head_wdata),
        .o_head_q     (head_q),
        .i_node_addr  (s_node_addr),
        .i_data_wdata ({r_key, r_val}),
        .i_link_wdata (s_link_wdata),
        .o_data_q     (data_q),
        .o_link_q     (link_q)
    );

    // sequencer: clear, hash, walk the chain, update the tables
    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_free       = r_free;
        n_count      = r_count;
        n_p          = r_p;
        n_prev       = r_prev;
        n_steps      = r_steps;
        n_head       = r_head;
        n_bucket     = r_bucket;
        n_status     = r_status;
        n_sv         = r_sv;
        s_ctl        = '0;
        s_head_addr  = r_bucket;
        s_head_wdata = r_free;
        s_node_addr  = r_p[NA-1:0];
        s_link_wdata = r_head;
        s_end        = 1'b0;
        s_hit        = 1'b0;

        unique case (r_state)
            S_CLR: begin
                s_ctl.head_we = (r_clr < XW'(BUCKETS_MAX));
                s_head_addr   = r_clr[BW-1:0];
                s_head_wdata  = NIL;
                s_ctl.link_we = (r_clr < XW'(NODES_MAX));
                s_node_addr   = r_clr[NA-1:0];
                s_link_wdata  = PW'(r_clr) + PW'(1);
                if (r_clr == XW'(CLR_N - 1))
                    n_state = S_IDLE;
                else
                    n_clr = r_clr + XW'(1);
            end
            S_IDLE: begin
                if (s_accept) begin
                    n_state = S_HASH;
                    n_steps = '0;
                    n_prev  = NIL;
                end
            end
            S_HASH: begin
                if (hs_done) begin
                    s_ctl.head_re = 1'b1;
                    s_head_addr   = hs_bucket;
                    n_bucket      = hs_bucket;
                    n_state       = S_HGET;
                end
            end
            S_HGET: begin
                n_head = head_q;
                if (head_q == NIL) begin
                    s_end = 1'b1;
                end else begin
                    s_ctl.node_re = 1'b1;
                    s_node_addr   = head_q[NA-1:0];
                    n_p           = head_q;
                    n_state       = S_NCMP;
                end
            end
            S_NCMP: begin
                if (data_q[DW-1:VAL_W] == r_key) begin
                    s_end = 1'b1;
                    s_hit = 1'b1;
                end else begin
                    n_prev  = r_p;
                    n_steps = r_steps + PW'(1);
                    if (link_q == NIL || n_steps >= NIL) begin
                        s_end = 1'b1;
                    end else begin
                        s_ctl.node_re = 1'b1;
                        s_node_addr   = link_q[NA-1:0];
                        n_p           = link_q;
                    end
                end
            end
            S_INS: begin
                // new node goes to the head of its chain
                s_ctl.data_we = 1'b1;
                s_ctl.link_we = 1'b1;
                s_ctl.head_we = 1'b1;
                s_node_addr   = r_free[NA-1:0];
                s_link_wdata  = r_head;
                s_head_wdata  = r_free;
                n_free        = link_q;
                n_count       = r_count + PW'(1);
                n_status      = ST_INSERTED;
                n_sv          = '0;
                n_state       = S_OUT;
            end
            S_REM1: begin
                // unlink from the predecessor or from the bucket head
                if (r_prev != NIL) begin
                    s_ctl.link_we = 1'b1;
                    s_node_addr   = r_prev[NA-1:0];
                end else begin
                    s_ctl.head_we = 1'b1;
                end
                s_link_wdata = link_q;
                s_head_wdata = link_q;
                n_state      = S_REM2;
            end
            S_REM2: begin
                // push the node back on the free list
                s_ctl.link_we = 1'b1;
                s_node_addr   = r_p[NA-1:0];
                s_link_wdata  = r_free;
                n_free        = r_p;
                if (r_count != '0) n_count = r_count - PW'(1);
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || i_m_axis_tready) n_state = S_IDLE;
            end
            default: n_state = S_CLR;
        endcase

        // walk finished: decide by command
        if (s_end) begin
            n_sv    = '0;
            n_state = S_OUT;
            case (r_cmd)
                CMD_INSERT: begin
                    if (s_hit) begin
                        n_status = ST_PRESENT;
                        n_sv     = data_q[VAL_W-1:0];
                    end else if (r_free == NIL) begin
                        n_status = ST_FULL;
                    end else begin
                        s_ctl.link_re = 1'b1;
                        s_node_addr   = r_free[NA-1:0];
                        n_state       = S_INS;
                    end
                end
                CMD_REMOVE: begin
                    if (s_hit) begin
                        n_status = ST_REMOVED;
                        n_sv     = data_q[VAL_W-1:0];
                        n_state  = S_REM1;
                    end else begin
                        n_status = ST_ABSENT;
                    end
                end
                default: begin
                    if (s_hit) begin
                        n_status = ST_FOUND;
                        n_sv     = data_q[VAL_W-1:0];
                    end else begin
                        n_status = ST_ABSENT;
                    end
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_free   <= '0;
            r_count  <= '0;
            r_start  <= 1'b0;
            r_ovalid <= 1'b0;
            r_bc     <= BUCKET_COUNT_RST;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_free  <= n_free;
            r_count <= n_count;
            r_start <= s_accept;
            if (i_cfg_we) r_bc <= i_cfg_wdata;
            if (s_oload)
                r_ovalid <= 1'b1;
            else if (i_m_axis_tready)
                r_ovalid <= 1'b0;
        end
    end

    // item and walk registers
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_cmd <= i_s_axis_tuser;
            r_key <= i_s_axis_tdata[2*KEY_W-1:0] & KEY_MASK;
            r_val <= i_s_axis_tdata[DW-1:2*KEY_W] & VAL_MASK;
        end
        r_p      <= n_p;
        r_prev   <= n_prev;
        r_steps  <= n_steps;
        r_head   <= n_head;
        r_bucket <= n_bucket;
        r_status <= n_status;
        r_sv     <= n_sv;
        if (s_oload) begin
            r_odata <= {5'b0, CNT_W'(r_count), r_sv};
            r_ouser <= r_status;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;

    // entry count never exceeds the node pool
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NIL)
        else $error("entry count above node pool");

    // free list is empty exactly when every node is held
    a_free_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free == NIL) == (r_count == NIL))
        else $error("free list and entry count disagree");

    // bucket index arrives only while the sequencer waits for it
    a_hash_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hs_done |-> r_state == S_HASH)
        else $error("hash result outside hash wait");

    // a result is loaded only into a free or draining output register
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_m_axis_tready && r_state == S_OUT) |=> r_state == S_OUT)
        else $error("result lost while output stalled");

endmodule
